### sv/tlcc_pkg.sv
package tlcc_pkg;

  localparam int LOG_DEPTH = 256;
  localparam int ADDR_W    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

  localparam int ID_W  = 8;
  localparam int SEQ_W = 16;
  localparam int AMT_W = 32;
  localparam int KEY_W = 2 * (ID_W + SEQ_W);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]  a_id;
    logic [SEQ_W-1:0] a_seq;
    logic [ID_W-1:0]  b_id;
    logic [SEQ_W-1:0] b_seq;
  } rec_key_t;

  typedef struct packed {
    logic              op;
    logic [ID_W-1:0]   x_id;
    logic [SEQ_W-1:0]  x_seq;
    logic [ID_W-1:0]   y_id;
    logic [SEQ_W-1:0]  y_seq;
    logic [AMT_W-1:0]  mag;
  } item_t;

  typedef struct packed {
    logic            hit;
    logic            ok;
    logic [ID_W-1:0] who;
    logic            dup;
  } cmp_res_t;

  function automatic logic [AMT_W-1:0] magnitude(input logic [AMT_W-1:0] v);
    return v[AMT_W-1] ? (~v + AMT_W'(1)) : v;
  endfunction

endpackage

### sv/tlcc_ram.sv
module tlcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
  input  logic [WIDTH-1:0]                 wdata,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### sv/tlcc_cmp.sv
module tlcc_cmp
  import tlcc_pkg::*;
(
  input  item_t            item,
  input  rec_key_t         rec_key,
  input  logic [AMT_W-1:0] rec_amount,
  output cmp_res_t         res
);

  logic same_mag;
  logic ax, ay, bx, by;

  assign same_mag = (magnitude(rec_amount) == item.mag);
  assign ax = (rec_key.a_id == item.x_id) && (rec_key.a_seq == item.x_seq);
  assign ay = (rec_key.a_id == item.y_id) && (rec_key.a_seq == item.y_seq);
  assign bx = (rec_key.b_id == item.x_id) && (rec_key.b_seq == item.x_seq);
  assign by = (rec_key.b_id == item.y_id) && (rec_key.b_seq == item.y_seq);

  // Priority: A against X, A against Y, B against X, B against Y.
  always_comb begin
    res.hit = ax || ay || bx || by;
    res.dup = (ax && by) || (ay && bx);
    if (ax) begin
      res.ok  = by && same_mag;
      res.who = rec_key.a_id;
    end else if (ay) begin
      res.ok  = bx && same_mag;
      res.who = rec_key.a_id;
    end else if (bx) begin
      res.ok  = ay && same_mag;
      res.who = rec_key.b_id;
    end else begin
      res.ok  = ax && same_mag;
      res.who = rec_key.b_id;
    end
  end

endmodule

### sv/transaction_log_conflict_checker_core.sv
// Transaction log conflict checker. Holds an ordered log of up to LOG_DEPTH
// two-party records. An insert beat appends the record unless the same key
// pair is logged in either orientation; a check beat scans from the oldest
// record, and the first record sharing a party/sequence pair with the beat
// decides: agreement on the other party, its sequence number and the
// absolute amount accepts it, otherwise the record's matching party id comes
// back as culprit. A check with no hit is appended. A full log drops the
// record and raises table_full. One beat at a time: the scan reads one record
// per cycle through the single compare unit and the log RAM read port, and
// stops early on a hit. in_stall stays high while an item is in work.
// No clearing pass is needed after reset: only entries below the fill count
// are ever read.
module transaction_log_conflict_checker_core
  import tlcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [ID_W-1:0]   in_party_x_id,
  input  logic [SEQ_W-1:0]  in_party_x_seq,
  input  logic [ID_W-1:0]   in_party_y_id,
  input  logic [SEQ_W-1:0]  in_party_y_seq,
  input  logic signed [AMT_W-1:0] in_amount,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_conflict,
  output logic [ID_W-1:0]   out_culprit_id,
  output logic              out_stored,
  output logic              out_table_full
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Item under work; the raw amount is kept for the append.
  item_t            item_r, item_nxt;
  logic [AMT_W-1:0] amt_r, amt_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;

  // Outcome decided by the scan, committed in S_FIN.
  logic             fin_store_r, fin_store_nxt;
  logic             fin_conflict_r, fin_conflict_nxt;
  logic [ID_W-1:0]  fin_culprit_r, fin_culprit_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_conflict_r, out_conflict_nxt;
  logic [ID_W-1:0]  out_culprit_r, out_culprit_nxt;
  logic             out_stored_r, out_stored_nxt;
  logic             out_full_r, out_full_nxt;

  logic             ram_en, ram_we;
  logic [ADDR_W-1:0] ram_addr;
  rec_key_t         wr_key, rd_key;
  logic [AMT_W-1:0] rd_amount;
  cmp_res_t         cmp;

  logic             in_acc, slot_free, hit_now, log_full;

  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign log_full  = (count_r == CNT_W'(LOG_DEPTH));
  assign hit_now   = rd_vld_r && ((item_r.op == OP_CHECK) ? cmp.hit : cmp.dup);

  assign wr_key = '{a_id: item_r.x_id, a_seq: item_r.x_seq,
                    b_id: item_r.y_id, b_seq: item_r.y_seq};

  tlcc_ram #(.WIDTH(KEY_W), .DEPTH(LOG_DEPTH)) u_keys (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (wr_key),
    .rdata (rd_key)
  );

  tlcc_ram #(.WIDTH(AMT_W), .DEPTH(LOG_DEPTH)) u_amounts (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (amt_r),
    .rdata (rd_amount)
  );

  tlcc_cmp u_cmp (
    .item       (item_r),
    .rec_key    (rd_key),
    .rec_amount (rd_amount),
    .res        (cmp)
  );

  always_comb begin
    state_nxt        = state_r;
    item_nxt         = item_r;
    amt_nxt          = amt_r;
    count_nxt        = count_r;
    idx_nxt          = idx_r;
    rd_vld_nxt       = rd_vld_r;
    fin_store_nxt    = fin_store_r;
    fin_conflict_nxt = fin_conflict_r;
    fin_culprit_nxt  = fin_culprit_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_conflict_nxt = out_conflict_r;
    out_culprit_nxt  = out_culprit_r;
    out_stored_nxt   = out_stored_r;
    out_full_nxt     = out_full_r;
    ram_en           = 1'b0;
    ram_we           = 1'b0;
    ram_addr         = idx_r[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          item_nxt = '{op: in_operation, x_id: in_party_x_id, x_seq: in_party_x_seq,
                       y_id: in_party_y_id, y_seq: in_party_y_seq,
                       mag: magnitude(in_amount)};
          amt_nxt    = in_amount;
          idx_nxt    = '0;
          rd_vld_nxt = 1'b0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit_now) begin
          // First hit decides; drop the rest of the scan.
          fin_store_nxt    = 1'b0;
          fin_conflict_nxt = (item_r.op == OP_CHECK) && !cmp.ok;
          fin_culprit_nxt  = fin_conflict_nxt ? cmp.who : '0;
          rd_vld_nxt       = 1'b0;
          state_nxt        = S_FIN;
        end else if (idx_r < count_r) begin
          // Issue the next record; its data is compared next cycle.
          ram_en     = 1'b1;
          idx_nxt    = idx_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
        end else begin
          rd_vld_nxt = 1'b0;
          if (!rd_vld_r) begin
            fin_store_nxt    = 1'b1;
            fin_conflict_nxt = 1'b0;
            fin_culprit_nxt  = '0;
            state_nxt        = S_FIN;
          end
        end
      end
      S_FIN: begin
        // Hold until the result register is free, then commit.
        if (slot_free) begin
          out_valid_nxt    = 1'b1;
          out_conflict_nxt = fin_conflict_r;
          out_culprit_nxt  = fin_culprit_r;
          out_stored_nxt   = fin_store_r && !log_full;
          out_full_nxt     = fin_store_r && log_full;
          if (fin_store_r && !log_full) begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = count_r[ADDR_W-1:0];
            count_nxt = count_r + CNT_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r         <= item_nxt;
    amt_r          <= amt_nxt;
    fin_store_r    <= fin_store_nxt;
    fin_conflict_r <= fin_conflict_nxt;
    fin_culprit_r  <= fin_culprit_nxt;
    out_conflict_r <= out_conflict_nxt;
    out_culprit_r  <= out_culprit_nxt;
    out_stored_r   <= out_stored_nxt;
    out_full_r     <= out_full_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_conflict   = out_conflict_r;
  assign out_culprit_id = out_culprit_r;
  assign out_stored     = out_stored_r;
  assign out_table_full = out_full_r;

  // Fill count never passes the log depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LOG_DEPTH))
    else $error("log fill count beyond depth");

  // Scan pointer never runs past the fill count.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= count_r)
    else $error("scan pointer beyond fill count");

  // A fresh result comes only out of the commit state.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && out_stall)) |-> $past(state_r == S_FIN))
    else $error("result without commit");

  // A stored result goes with exactly one new log entry.
  a_store_count: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r == S_FIN) && state_r == S_IDLE && out_stored_r)
      |-> count_r == $past(count_r) + CNT_W'(1))
    else $error("stored flag without log growth");

endmodule

### bench/tb_transaction_log_conflict_checker_core.sv
module tb_transaction_log_conflict_checker_core
  import tlcc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Receiver hold-off for the pressure test, and the cycle budget without any
  // accepted beat. The limit covers a full-log scan, the hold-off and every
  // random gap several times.
  localparam int HOLD_CYCLES    = 320;
  localparam int WATCHDOG_LIMIT = 4000;

  // One expected result beat.
  typedef struct packed {
    logic            conflict;
    logic [ID_W-1:0] culprit;
    logic            stored;
    logic            full;
  } verdict_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_operation;
  logic [ID_W-1:0]         in_party_x_id;
  logic [SEQ_W-1:0]        in_party_x_seq;
  logic [ID_W-1:0]         in_party_y_id;
  logic [SEQ_W-1:0]        in_party_y_seq;
  logic signed [AMT_W-1:0] in_amount;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_conflict;
  logic [ID_W-1:0]         out_culprit_id;
  logic                    out_stored;
  logic                    out_table_full;

  // Shadow copy of the log, updated at most once per accepted input beat.
  rec_key_t         ledger_keys [LOG_DEPTH];
  logic [AMT_W-1:0] ledger_amts [LOG_DEPTH];
  int               ledger_fill;

  verdict_t pending_verdicts[$];
  verdict_t want;
  int       error_count;
  int       quiet_cycles;
  int       stall_left;
  bit       idle_on;
  bit       hold_req;

  transaction_log_conflict_checker_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_party_x_id  (in_party_x_id),
    .in_party_x_seq (in_party_x_seq),
    .in_party_y_id  (in_party_y_id),
    .in_party_y_seq (in_party_y_seq),
    .in_amount      (in_amount),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_conflict   (out_conflict),
    .out_culprit_id (out_culprit_id),
    .out_stored     (out_stored),
    .out_table_full (out_table_full)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Print one line per mismatch and count it.
  task automatic report_error(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Magnitude as 32-bit unsigned: the most negative amount maps onto 2^31.
  function automatic logic [AMT_W-1:0] abs_amount(input logic [AMT_W-1:0] v);
    return v[AMT_W-1] ? (32'd0 - v) : v;
  endfunction

  // Append to the shadow log, or flag a full log and drop the record.
  function automatic verdict_t store_record(input rec_key_t key,
                                            input logic [AMT_W-1:0] amt);
    verdict_t v;
    v = '0;
    if (ledger_fill >= LOG_DEPTH) begin
      v.full = 1'b1;
    end else begin
      ledger_keys[ledger_fill] = key;
      ledger_amts[ledger_fill] = amt;
      ledger_fill++;
      v.stored = 1'b1;
    end
    return v;
  endfunction

  // Work out the result of one beat; key.a is party X, key.b is party Y.
  function automatic verdict_t log_outcome(input logic op, input rec_key_t key,
                                           input logic [AMT_W-1:0] amt);
    verdict_t        v;
    rec_key_t        r;
    rec_key_t        swapped;
    logic [AMT_W-1:0] mag;
    bit              hit;
    bit              ok;
    bit              same_mag;
    logic [ID_W-1:0] who;
    v = '0;
    mag = abs_amount(amt);
    swapped = '{a_id: key.b_id, a_seq: key.b_seq, b_id: key.a_id, b_seq: key.a_seq};
    if (op == OP_INSERT) begin
      // Drop the insert if the pair is logged in either orientation.
      for (int i = 0; i < ledger_fill; i++) begin
        if (ledger_keys[i] == key || ledger_keys[i] == swapped) return v;
      end
      return store_record(key, amt);
    end
    // Oldest record first; the first party/sequence hit decides.
    for (int i = 0; i < ledger_fill; i++) begin
      r = ledger_keys[i];
      same_mag = abs_amount(ledger_amts[i]) == mag;
      hit = 1'b1;
      ok = 1'b0;
      who = '0;
      if (r.a_id == key.a_id && r.a_seq == key.a_seq) begin
        ok = r.b_id == key.b_id && r.b_seq == key.b_seq && same_mag;
        who = r.a_id;
      end else if (r.a_id == key.b_id && r.a_seq == key.b_seq) begin
        ok = r.b_id == key.a_id && r.b_seq == key.a_seq && same_mag;
        who = r.a_id;
      end else if (r.b_id == key.a_id && r.b_seq == key.a_seq) begin
        ok = r.a_id == key.b_id && r.a_seq == key.b_seq && same_mag;
        who = r.b_id;
      end else if (r.b_id == key.b_id && r.b_seq == key.b_seq) begin
        ok = r.a_id == key.a_id && r.a_seq == key.a_seq && same_mag;
        who = r.b_id;
      end else begin
        hit = 1'b0;
      end
      if (hit) begin
        if (!ok) begin
          v.conflict = 1'b1;
          v.culprit = who;
        end
        return v;
      end
    end
    return store_record(key, amt);
  endfunction

  // Offer one beat at the falling edge, hold it until accepted, then queue
  // its expected result. Returns at the rising edge of acceptance.
  task automatic send_beat(input logic op,
                           input logic [ID_W-1:0] xi, input logic [SEQ_W-1:0] xs,
                           input logic [ID_W-1:0] yi, input logic [SEQ_W-1:0] ys,
                           input logic [AMT_W-1:0] amt);
    int       gap;
    rec_key_t key;
    key = '{a_id: xi, a_seq: xs, b_id: yi, b_seq: ys};
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = int'($urandom_range(1, 4));
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_operation   = op;
    in_party_x_id  = xi;
    in_party_x_seq = xs;
    in_party_y_id  = yi;
    in_party_y_seq = ys;
    in_amount      = amt;
    in_valid       = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_verdicts = {pending_verdicts, log_outcome(op, key, amt)};
  endtask

  // Drop valid and hold the sender until every queued result has come back.
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // One random beat. Most beats reuse a logged record so that duplicates,
  // agreeing checks and conflicts come up; the rest are fresh full-range
  // keys (which fill the log) or keys from a tiny space that collide often.
  task automatic random_beat();
    int               pick;
    int               idx;
    logic             op;
    logic [ID_W-1:0]  xi;
    logic [ID_W-1:0]  yi;
    logic [SEQ_W-1:0] xs;
    logic [SEQ_W-1:0] ys;
    logic [AMT_W-1:0] amt;
    rec_key_t         k;
    pick = int'($urandom_range(0, 99));
    op  = 1'($urandom_range(0, 1));
    xi  = ID_W'($urandom);
    xs  = SEQ_W'($urandom);
    yi  = ID_W'($urandom);
    ys  = SEQ_W'($urandom);
    amt = AMT_W'($urandom);
    if (pick < 15) begin
      xi  = ID_W'($urandom_range(0, 3));
      xs  = SEQ_W'($urandom_range(0, 3));
      yi  = ID_W'($urandom_range(0, 3));
      ys  = SEQ_W'($urandom_range(0, 3));
      amt = AMT_W'($urandom_range(0, 6) - 3);
    end else if (pick >= 45 && ledger_fill > 0) begin
      idx = int'($urandom_range(0, ledger_fill - 1));
      k   = ledger_keys[idx];
      amt = ledger_amts[idx];
      if ($urandom_range(0, 1)) {xi, xs, yi, ys} = {k.a_id, k.a_seq, k.b_id, k.b_seq};
      else                      {xi, xs, yi, ys} = {k.b_id, k.b_seq, k.a_id, k.a_seq};
      if ($urandom_range(0, 1)) amt = 32'd0 - amt;
      op = OP_CHECK;
      case ($urandom_range(0, 4))
        0: op = OP_INSERT;
        1: begin
          // keep the beat in agreement with the record
        end
        2: yi = yi + ID_W'($urandom_range(1, 255));
        3: begin
          if ($urandom_range(0, 1)) ys = ys + SEQ_W'($urandom_range(1, 3));
          else                      xs = xs + SEQ_W'($urandom_range(1, 3));
        end
        default: amt = amt + AMT_W'($urandom_range(1, 2));
      endcase
    end
    send_beat(op, xi, xs, yi, ys, amt);
  endtask

  // Inserts on an empty log: extremes of every field, then duplicates in both
  // orientations and a near miss that differs in one sequence number only.
  task automatic test_insert_dedup();
    send_beat(OP_INSERT, 8'h00, 16'h0000, 8'h00, 16'h0000, 32'h0000_0000);
    send_beat(OP_INSERT, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 32'h8000_0000);
    send_beat(OP_INSERT, 8'h12, 16'h0100, 8'h34, 16'h0200, 32'h7FFF_FFFF);
    send_beat(OP_INSERT, 8'h12, 16'h0100, 8'h34, 16'h0200, 32'h0000_0011);
    send_beat(OP_INSERT, 8'h34, 16'h0200, 8'h12, 16'h0100, 32'h7FFF_FFFF);
    send_beat(OP_INSERT, 8'h12, 16'h0100, 8'h34, 16'h0201, 32'h0000_0005);
  endtask

  // Checks: agreement in swapped orientation with a negated amount, hits on
  // each of the four party tests, a check that logs a new record, and the
  // most negative amount against the largest positive one.
  task automatic test_check_outcomes();
    send_beat(OP_CHECK, 8'h34, 16'h0200, 8'h12, 16'h0100, 32'h8000_0001);
    send_beat(OP_CHECK, 8'h12, 16'h0100, 8'h34, 16'h0200, 32'h0000_0007);
    send_beat(OP_CHECK, 8'h55, 16'h0001, 8'h12, 16'h0100, 32'h7FFF_FFFF);
    send_beat(OP_CHECK, 8'h40, 16'h0010, 8'h41, 16'h0020, 32'hFFFF_FFF7);
    send_beat(OP_CHECK, 8'h41, 16'h0020, 8'h77, 16'h0077, 32'h0000_0009);
    send_beat(OP_CHECK, 8'h66, 16'h0006, 8'h41, 16'h0020, 32'h0000_0009);
    send_beat(OP_CHECK, 8'h41, 16'h0020, 8'h40, 16'h0010, 32'h0000_0009);
    send_beat(OP_CHECK, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 32'h7FFF_FFFF);
    send_beat(OP_CHECK, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 32'h8000_0000);
    send_beat(OP_CHECK, 8'h00, 16'h0000, 8'h00, 16'h0000, 32'h0000_0000);
  endtask

  // The oldest hitting record decides even when a later one would agree.
  task automatic test_scan_order();
    send_beat(OP_INSERT, 8'h90, 16'h0001, 8'h91, 16'h0001, 32'h0000_0001);
    send_beat(OP_INSERT, 8'h92, 16'h0001, 8'h90, 16'h0001, 32'h0000_0002);
    send_beat(OP_CHECK,  8'h92, 16'h0001, 8'h90, 16'h0001, 32'h0000_0002);
  endtask

  // Hold the result side off for a long stretch while beats keep coming, so
  // the block backs up onto its input; pause until all results are in, then send four more.
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_req = 1'b1;
    repeat (6) random_beat();
    wait_for_drain();
    repeat (4) random_beat();
  endtask

  task automatic test_random_mix(input int count);
    idle_on = 1'b1;
    for (int n = 0; n < count; n++) begin
      random_beat();
      if (n % 250 == 249) wait_for_drain();
    end
  endtask

  // Last stretch: back-to-back beats with no idling on either side.
  task automatic test_random_steady(input int count);
    idle_on = 1'b0;
    repeat (count) random_beat();
  endtask

  // Receiver: random stall bursts while idling is on, and
  // the long hold-off when the pressure test asks for it.
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        stall_left = int'($urandom_range(0, 3));
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        report_error("result beat with no item outstanding");
      end else begin
        want = pending_verdicts.pop_front();
        if (out_conflict !== want.conflict)
          report_error($sformatf("conflict %b, expected %b", out_conflict, want.conflict));
        if (out_culprit_id !== want.culprit)
          report_error($sformatf("culprit_id %h, expected %h", out_culprit_id, want.culprit));
        if (out_stored !== want.stored)
          report_error($sformatf("stored %b, expected %b", out_stored, want.stored));
        if (out_table_full !== want.full)
          report_error($sformatf("table_full %b, expected %b", out_table_full, want.full));
      end
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_INSERT;
    in_party_x_id  = '0;
    in_party_x_seq = '0;
    in_party_y_id  = '0;
    in_party_y_seq = '0;
    in_amount      = '0;
    idle_on        = 1'b0;
    hold_req       = 1'b0;
    ledger_fill    = 0;
    error_count    = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_insert_dedup();
    test_check_outcomes();
    test_scan_order();
    test_backpressure();
    test_random_mix(1000);
    test_random_steady(230);

    // Drop valid, collect the tail, then allow one full scan for strays.
    @(negedge clk);
    in_valid = 1'b0;
    wait_for_drain();
    repeat (LOG_DEPTH + 16) @(posedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
